### hw/rtl/assert_macros.svh
// Assertion helpers shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error(msg);

`endif

### hw/rtl/vsd_pkg.sv
`timescale 1ns / 1ps
package vsd_pkg;

    localparam int VSD_QUEUE_DEPTH = 4;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 2;

    localparam logic [7:0] BYTE_CONT     = 8'h80;
    localparam logic [7:0] BYTE_MIN_CODE = 8'h40;
    localparam logic [7:0] BYTE_ALL      = 8'hFF;
    localparam logic [6:0] SIGNED_FIRST_BITS = 7'd6;
    localparam logic [6:0] GROUP_BITS        = 7'd7;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VALUE_WIDTH = 1'd0,
        CFG_SIGNED_MODE = 1'd1
    } vsd_cfg_index_t;

    typedef enum logic [1:0] {
        WC_8  = 2'd0,
        WC_16 = 2'd1,
        WC_32 = 2'd2,
        WC_64 = 2'd3
    } vsd_width_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TRUNC    = 2'd1,
        ST_NONCANON = 2'd2,
        ST_OVERFLOW = 2'd3
    } vsd_status_t;

    typedef enum logic [2:0] {
        KIND_FINISH,
        KIND_MIN,
        KIND_MAX,
        KIND_NONCANON,
        KIND_TRUNC
    } vsd_kind_t;

    typedef struct packed {
        vsd_kind_t   kind;
        logic [63:0] acc;
        logic        neg;
        logic [1:0]  width_code;
        logic        sgn;
        logic [3:0]  length;
    } vsd_entry_t;

    typedef struct packed {
        logic       valid;
        vsd_entry_t entry;
    } vsd_beat_t;

    function automatic logic [63:0] width_mask(input logic [1:0] wc);
        logic [63:0] m;
        case (wc)
            WC_8:    m = 64'h0000_0000_0000_00FF;
            WC_16:   m = 64'h0000_0000_0000_FFFF;
            WC_32:   m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [6:0] width_bits(input logic [1:0] wc);
        logic [6:0] w;
        case (wc)
            WC_8:    w = 7'd8;
            WC_16:   w = 7'd16;
            WC_32:   w = 7'd32;
            default: w = 7'd64;
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/vsd_in_if.sv
`timescale 1ns / 1ps
interface vsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_in_buffer;

    modport source (output valid, output byte_value, output last_in_buffer, input ready);
    modport sink   (input valid, input byte_value, input last_in_buffer, output ready);
endinterface

### hw/rtl/vsd_out_if.sv
`timescale 1ns / 1ps
interface vsd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [1:0]  status;
    logic [3:0]  length;

    modport source (output valid, output value, output status, output length, input ready);
    modport sink   (input valid, input value, input status, input length, output ready);
endinterface

### hw/rtl/vsd_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vsd_front
    import vsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    vsd_in_if.sink     byte_chan,
    input  logic [1:0] value_width,
    input  logic       signed_mode,
    input  logic       q_full,
    output vsd_beat_t  push
);

    logic        in_prog_reg, in_prog_next;
    logic [63:0] acc_reg, acc_next;
    logic [6:0]  bitpos_reg, bitpos_next;
    logic [3:0]  bytes_seen_reg, bytes_seen_next;
    logic [7:0]  first_byte_reg, first_byte_next;

    logic              accept;
    logic              opening;
    logic [7:0]        b;
    logic [3:0]        len;
    logic [63:0]       mask;
    logic [6:0]        bp;
    logic [63:0]       acc_base;
    logic [7:0]        fb;
    logic [6:0]        lim;
    logic signed [7:0] left;
    logic [63:0]       shifted;
    logic [63:0]       acc_cont;
    logic [63:0]       acc_open;
    logic [7:0]        high_bits;
    logic              excess;
    logic              emit;
    vsd_kind_t         kind;
    logic [63:0]       acc_out;

    assign byte_chan.ready = !q_full;
    assign accept = byte_chan.valid && byte_chan.ready;

    always_comb
    begin
        b        = byte_chan.byte_value;
        opening  = !in_prog_reg;
        len      = bytes_seen_reg + 4'd1;
        mask     = width_mask(value_width);
        bp       = opening ? 7'd0 : bitpos_reg;
        acc_base = opening ? 64'd0 : acc_reg;
        fb       = opening ? b : first_byte_reg;
        lim      = signed_mode ? (width_bits(value_width) - 7'd1) : width_bits(value_width);
        left     = $signed({1'b0, lim}) - $signed({1'b0, bp});
        shifted  = bp[6] ? 64'd0 : ({57'd0, b[6:0]} << bp[5:0]);
        acc_cont = (acc_base | shifted) & mask;
        acc_open = {58'd0, b[5:0]};
        high_bits = b & (BYTE_ALL << left[2:0]);
        // Bits of this byte that would land at or above the usable width.
        excess   = (left < 8'sd8) && ((left <= 8'sd0) ? (b != 8'd0) : (high_bits != 8'd0));

        emit        = 1'b0;
        kind        = KIND_FINISH;
        acc_out     = acc_cont;
        acc_next    = acc_cont;
        bitpos_next = bp + GROUP_BITS;

        if (opening && signed_mode)
        begin
            acc_out  = acc_open;
            acc_next = acc_open;
            if (b == BYTE_MIN_CODE)
            begin
                emit = 1'b1;
                kind = KIND_MIN;
            end
            else if (!b[7])
            begin
                emit = 1'b1;
                kind = KIND_FINISH;
            end
            else
            begin
                bitpos_next = SIGNED_FIRST_BITS;
                if (byte_chan.last_in_buffer)
                begin
                    emit = 1'b1;
                    kind = KIND_TRUNC;
                end
            end
        end
        else if (!opening && (b == 8'd0))
        begin
            emit = 1'b1;
            kind = ((len == 4'd2) && (first_byte_reg == BYTE_CONT)) ? KIND_MAX : KIND_NONCANON;
        end
        else if (excess)
        begin
            emit = 1'b1;
            kind = KIND_NONCANON;
        end
        else if (b[7])
        begin
            if (byte_chan.last_in_buffer)
            begin
                emit = 1'b1;
                kind = KIND_TRUNC;
            end
        end
        else
        begin
            emit = 1'b1;
            kind = KIND_FINISH;
        end

        if (emit)
        begin
            in_prog_next    = 1'b0;
            acc_next        = 64'd0;
            bitpos_next     = 7'd0;
            bytes_seen_next = 4'd0;
            first_byte_next = 8'd0;
        end
        else
        begin
            in_prog_next    = 1'b1;
            bytes_seen_next = len;
            first_byte_next = fb;
        end

        push.valid            = accept && emit;
        push.entry.kind       = kind;
        push.entry.acc        = acc_out;
        push.entry.neg        = fb[6];
        push.entry.width_code = value_width;
        push.entry.sgn        = signed_mode;
        push.entry.length     = len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_prog_reg    <= 1'b0;
            acc_reg        <= 64'd0;
            bitpos_reg     <= 7'd0;
            bytes_seen_reg <= 4'd0;
            first_byte_reg <= 8'd0;
        end
        else if (accept)
        begin
            in_prog_reg    <= in_prog_next;
            acc_reg        <= acc_next;
            bitpos_reg     <= bitpos_next;
            bytes_seen_reg <= bytes_seen_next;
            first_byte_reg <= first_byte_next;
        end
    end

    `ASSERT_PROP(a_emit_restarts, clk, rst_n, push.valid |=> (!in_prog_reg && (bytes_seen_reg == 4'd0)), "decoder state not cleared after a result")

endmodule

### hw/rtl/vsd_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vsd_queue
    import vsd_pkg::*;
#(
    parameter int DEPTH = VSD_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  vsd_beat_t push,
    output logic      full,
    output vsd_beat_t head,
    input  logic      pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    vsd_entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             empty;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;

    assign head.valid = !empty;
    assign head.entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_NEVER(a_no_push_full, clk, rst_n, push.valid && full, "result pushed into a full queue")
    `ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > FULL_CNT, "queue count beyond its depth")

endmodule

### hw/rtl/vsd_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vsd_back
    import vsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  vsd_beat_t  head,
    output logic       pop,
    vsd_out_if.source  result_chan
);

    logic        valid_reg;
    logic [63:0] value_reg, value_next;
    vsd_status_t status_reg, status_next;
    logic [3:0]  length_reg;

    vsd_entry_t  e;
    logic [63:0] m;
    logic [63:0] mag;
    logic [63:0] sv;
    logic [63:0] smax;
    logic [63:0] smin;

    assign pop = head.valid && (!valid_reg || result_chan.ready);

    assign result_chan.valid  = valid_reg;
    assign result_chan.value  = value_reg;
    assign result_chan.status = status_reg;
    assign result_chan.length = length_reg;

    always_comb
    begin
        e    = head.entry;
        m    = width_mask(e.width_code);
        mag  = e.acc & m;
        sv   = (e.neg ? (64'd0 - mag) : mag) & m;
        smax = m >> 1;
        smin = smax + 64'd1;

        value_next  = 64'd0;
        status_next = ST_NONCANON;
        case (e.kind)
            KIND_FINISH:
            begin
                if (!e.sgn)
                begin
                    // An all-ones plain encoding is reserved for the two-byte max code.
                    if (mag != m)
                    begin
                        value_next  = mag;
                        status_next = ST_OK;
                    end
                end
                else if ((sv != smax) && (sv != smin))
                begin
                    value_next  = ((sv & smin) != 64'd0) ? (sv | ~m) : sv;
                    status_next = ST_OK;
                end
            end
            KIND_MIN:
            begin
                value_next  = ~smax;
                status_next = ST_OK;
            end
            KIND_MAX:
            begin
                value_next  = e.sgn ? smax : m;
                status_next = ST_OK;
            end
            KIND_TRUNC:
            begin
                status_next = ST_TRUNC;
            end
            default:
            begin
                status_next = ST_NONCANON;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_chan.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
            length_reg <= e.length;
        end
    end

    `ASSERT_PROP(a_err_zero, clk, rst_n, (valid_reg && (status_reg != ST_OK)) |-> (value_reg == 64'd0), "error result carries a nonzero value")
    `ASSERT_PROP(a_pop_fills, clk, rst_n, pop |=> valid_reg, "popped entry did not reach the output register")

endmodule

### hw/rtl/varint_stream_decoder_unit.sv
`timescale 1ns / 1ps
// Streaming LEB128-style varint decoder, one encoded byte per input beat.
// byte_chan carries byte_value and last_in_buffer; result_chan carries value,
// status and length, one beat per finished, failed or truncated varint. Both
// use valid/ready, and a beat moves on a rising edge with both high.
// Throughput is one byte per cycle while the queue has room, set by the front
// stage, which merges each byte into the running accumulator with a single
// shift-and-or per cycle. result_chan.valid rises once the result of the byte
// ending a varint has moved from the queue into the output register, and the
// result beat leaves that register at an edge with the receiver ready.
// When result_chan stalls, finished results collect in the queue and bytes are
// still taken until it fills; byte_chan.ready then drops until a slot frees.
// Reset clears the decoder state, empties the queue, drops result_chan.valid
// and restores value_width to 64 bits and signed_mode to unsigned.
// The cfg port writes value_width (index 0) and signed_mode (index 1) on any
// edge with cfg_we high; change them only while no varint is in flight.
module varint_stream_decoder_unit
    import vsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = VSD_QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    vsd_in_if.sink                 byte_chan,
    vsd_out_if.source              result_chan,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers, read by the front stage on every byte.
    logic [1:0] value_width_reg;
    logic       signed_mode_reg;

    // Front to queue, queue to back.
    vsd_beat_t push;
    vsd_beat_t head;
    logic      q_full;
    logic      pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_width_reg <= WC_64;
            signed_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VALUE_WIDTH: value_width_reg <= cfg_data[1:0];
                CFG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                default:         value_width_reg <= value_width_reg;
            endcase
        end
    end

    // The front stage tracks the varint in progress and classifies how each
    // byte ends it, if at all; only bytes that end a varint enter the queue.
    vsd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_chan   (byte_chan),
        .value_width (value_width_reg),
        .signed_mode (signed_mode_reg),
        .q_full      (q_full),
        .push        (push)
    );

    vsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    // The back stage applies sign, range and canonical checks and holds the
    // result beat until the receiver takes it.
    vsd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .result_chan (result_chan)
    );

endmodule

### tb/sv/varint_stream_decoder_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming varint decoder.
module varint_stream_decoder_unit_tb;
    import vsd_pkg::*;

    // The run is short; this bound only catches a hung handshake.
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_BYTES    = 88;
    // A result passes through the queue and the output register before it leaves
    // the block; the settle time also covers bytes that changed only the running state.
    localparam int SETTLE_CYCLES  = 6;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic [63:0] value;
        vsd_status_t status;
        logic [3:0]  length;
    } decode_result_t;

    logic clk;
    logic rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    vsd_in_if  byte_if ();
    vsd_out_if result_if ();

    varint_stream_decoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_chan   (byte_if),
        .result_chan (result_if),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Bytes waiting to be driven, and results the decoder still owes us.
    byte_item_t     pending_bytes[$];
    decode_result_t expected_results[$];

    int  bytes_queued;
    int  bytes_accepted;
    int  mismatch_count;
    int  cycle_count;
    bit  byte_taken;
    // When set, neither side inserts idle cycles.
    bit  calm;

    // Register copies used by the stimulus generator. They follow the writes
    // issued from the sequence below.
    vsd_width_t gen_width;
    logic       gen_signed;

    // Decoder state as predicted by the testbench. The register copies here
    // are updated from the configuration port itself, at the same edge as
    // the block sees the write.
    vsd_width_t  pred_width;
    logic        pred_signed;
    logic        dec_busy;
    logic [63:0] dec_acc;
    logic [6:0]  dec_pos;
    logic [3:0]  dec_count;
    logic [7:0]  dec_first;

    // Outcome of the most recent predicted byte.
    bit             step_got;
    decode_result_t step_res;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // All bits of the chosen width set.
    function automatic logic [63:0] full_mask(input logic [1:0] wc);
        if (wc == WC_64)
            return '1;
        return (64'd1 << (8 << wc)) - 64'd1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s at cycle %0d: got 0x%0h, expected 0x%0h",
                 what, cycle_count, got, want);
        mismatch_count++;
    endtask

    // Produce one result and return the decoder to its idle state. A status
    // other than ok always carries a zero value.
    task close_varint(input logic [63:0] v, input vsd_status_t st);
        step_got        = 1'b1;
        step_res.value  = (st == ST_OK) ? v : 64'd0;
        step_res.status = st;
        step_res.length = dec_count;
        dec_busy  = 1'b0;
        dec_acc   = '0;
        dec_pos   = '0;
        dec_count = '0;
        dec_first = '0;
    endtask

    // A varint ended normally: apply the sign and reject a plain encoding of
    // the maximum and, when signed, the minimum, which have short codes of their own.
    task complete_varint();
        logic [63:0] m;
        logic [63:0] v;
        logic [63:0] smax;
        logic [63:0] smin;
        m = full_mask(pred_width);
        v = dec_acc & m;
        if (!pred_signed) begin
            if (v == m)
                close_varint(64'd0, ST_NONCANON);
            else
                close_varint(v, ST_OK);
        end
        else begin
            if (dec_first[6])
                v = -v;
            v    = v & m;
            smax = m >> 1;
            smin = smax + 64'd1;
            if (v == smax || v == smin)
                close_varint(64'd0, ST_NONCANON);
            else begin
                if ((v & smin) != 64'd0)
                    v = v | ~m;
                close_varint(v, ST_OK);
            end
        end
    endtask

    // Advance the predicted decoder by one accepted byte.
    task decode_byte(input logic [7:0] b, input logic last);
        logic [63:0] m;
        int          w;
        int          lim;
        int          left;
        bit          opening;
        step_got  = 1'b0;
        w         = 8 << pred_width;
        m         = full_mask(pred_width);
        opening   = !dec_busy;
        dec_count = dec_count + 4'd1;

        if (opening) begin
            dec_first = b;
            dec_acc   = '0;
            dec_pos   = '0;
            if (pred_signed) begin
                // The lone minimum code stands for the most negative value.
                if (b == BYTE_MIN_CODE) begin
                    close_varint(~(m >> 1), ST_OK);
                    return;
                end
                // First signed byte: six magnitude bits, sign in bit 6.
                dec_acc = {58'd0, b[5:0]};
                if (!b[7]) begin
                    complete_varint();
                    return;
                end
                dec_pos  = SIGNED_FIRST_BITS;
                dec_busy = 1'b1;
                if (last)
                    close_varint(64'd0, ST_TRUNC);
                return;
            end
        end

        // A zero continuation byte is only legal as the maximum-value pair.
        if (b == 8'h00 && !opening) begin
            if (dec_count == 4'd2 && dec_first == BYTE_CONT)
                close_varint(pred_signed ? (m >> 1) : m, ST_OK);
            else
                close_varint(64'd0, ST_NONCANON);
            return;
        end

        // Any bit at or above the usable width makes the encoding invalid.
        lim  = pred_signed ? w - 1 : w;
        left = lim - int'(dec_pos);
        if (left < 8) begin
            if (left <= 0) begin
                if (b != 8'h00) begin
                    close_varint(64'd0, ST_NONCANON);
                    return;
                end
            end
            else if ((b & (8'hFF << left)) != 8'h00) begin
                close_varint(64'd0, ST_NONCANON);
                return;
            end
        end

        if (dec_pos < 7'd64)
            dec_acc = dec_acc | ({57'd0, b[6:0]} << dec_pos);
        dec_acc = dec_acc & m;

        if (b[7]) begin
            dec_pos  = dec_pos + GROUP_BITS;
            dec_busy = 1'b1;
            if (last)
                close_varint(64'd0, ST_TRUNC);
            return;
        end
        complete_varint();
    endtask

    // Sampling side: everything here looks at values that were settled at the
    // preceding falling edge, so the order of processes at this edge does not
    // matter.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
        else if (rst_n) begin
            // Result beat: compare against the oldest outstanding expectation.
            if (result_if.valid && result_if.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result value", result_if.value, 64'd0);
                end
                else begin
                    decode_result_t want;
                    want = expected_results.pop_front();
                    if (result_if.value !== want.value)
                        report_mismatch("value", result_if.value, want.value);
                    if (result_if.status !== want.status)
                        report_mismatch("status", 64'(result_if.status), 64'(want.status));
                    if (result_if.length !== want.length)
                        report_mismatch("length", 64'(result_if.length), 64'(want.length));
                end
            end

            // Byte beat: run the predictor and remember what it owes us.
            if (byte_if.valid && byte_if.ready) begin
                decode_byte(byte_if.byte_value, byte_if.last_in_buffer);
                bytes_accepted++;
                if (step_got)
                    expected_results.push_back(step_res);
            end

            if (cfg_we) begin
                case (vsd_cfg_index_t'(cfg_index))
                    CFG_VALUE_WIDTH: pred_width  = vsd_width_t'(cfg_data[1:0]);
                    CFG_SIGNED_MODE: pred_signed = cfg_data[0];
                    default: ;
                endcase
            end
        end
        byte_taken <= rst_n && byte_if.valid && byte_if.ready;
    end

    // Driving side: inputs only change at the falling edge. A new byte is
    // offered once the previous one has gone, or when the channel was idle.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!byte_if.valid || byte_taken) begin
                if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 17)) begin
                    byte_item_t nxt;
                    nxt = pending_bytes.pop_front();
                    byte_if.valid          <= 1'b1;
                    byte_if.byte_value     <= nxt.data;
                    byte_if.last_in_buffer <= nxt.last;
                end
                else begin
                    byte_if.valid <= 1'b0;
                end
            end
            result_if.ready <= calm || ($urandom_range(0, 99) >= 17);
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic last);
        pending_bytes.push_back({b, last});
        bytes_queued++;
    endtask

    task automatic write_reg(input vsd_cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Program both registers. The upper data bit of the mode write is noise
    // that the block has to ignore.
    task automatic configure(input vsd_width_t wc, input logic sgn);
        write_reg(CFG_VALUE_WIDTH, wc);
        write_reg(CFG_SIGNED_MODE, {1'($urandom_range(0, 1)), sgn});
        gen_width  = wc;
        gen_signed = sgn;
    endtask

    // Hold the sender until every byte has been taken and every expected
    // result has come back, then let the block settle.
    task automatic wait_idle();
        while (bytes_accepted != bytes_queued || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Encode a magnitude (and sign in signed mode) as a well-formed varint.
    // With cut set, the encoding is broken off by a last byte that still asks
    // for more.
    task automatic queue_varint(input logic [63:0] mag, input logic neg,
                                input bit cut, input bit last_end);
        logic [7:0]  enc[$];
        logic [63:0] rest;
        int          stop;
        rest = mag;
        if (gen_signed) begin
            enc.push_back({1'b0, neg, rest[5:0]});
            rest = rest >> 6;
        end
        else begin
            enc.push_back({1'b0, rest[6:0]});
            rest = rest >> 7;
        end
        while (rest != 64'd0) begin
            enc[enc.size() - 1] = enc[enc.size() - 1] | BYTE_CONT;
            enc.push_back({1'b0, rest[6:0]});
            rest = rest >> 7;
        end
        if (cut) begin
            stop = $urandom_range(0, enc.size() - 1);
            enc[stop] = enc[stop] | BYTE_CONT;
            for (int i = 0; i <= stop; i++)
                queue_byte(enc[i], i == stop);
        end
        else begin
            for (int i = 0; i < enc.size(); i++)
                queue_byte(enc[i], (i == enc.size() - 1) && last_end);
        end
    endtask

    task automatic queue_random_varint();
        int          lim;
        int          nbits;
        logic [63:0] mag;
        lim   = (8 << gen_width) - (gen_signed ? 1 : 0);
        nbits = $urandom_range(0, lim);
        mag   = {$urandom, $urandom};
        if (nbits < 64)
            mag = mag & ((64'd1 << nbits) - 64'd1);
        queue_varint(mag, 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0,
                     $urandom_range(0, 3) == 0);
    endtask

    // One of the special encodings, picked at random.
    task automatic queue_special();
        logic [63:0] m;
        int          groups;
        m = full_mask(gen_width);
        case ($urandom_range(0, 5))
            0: queue_byte(BYTE_MIN_CODE, 1'($urandom_range(0, 1)));
            1: begin
                queue_byte(BYTE_CONT, 1'b0);
                queue_byte(8'h00, 1'($urandom_range(0, 1)));
            end
            // Plain encoding of the largest value, which must be rejected.
            2: queue_varint(gen_signed ? (m >> 1) : m, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
            // Values just inside the extremes are legal.
            3: queue_varint(gen_signed ? ((m >> 1) - 64'd1) : (m - 64'd1),
                            1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)));
            // Zero continuation byte after one or two leading bytes.
            4: begin
                queue_byte(8'($urandom_range(8'h81, 8'hFF)), 1'b0);
                if ($urandom_range(0, 1))
                    queue_byte(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
                queue_byte(8'h00, 1'($urandom_range(0, 1)));
            end
            // Fill every group up to the width, then end with a byte that may
            // reach past it.
            default: begin
                if (gen_signed) begin
                    queue_byte(8'hBF, 1'b0);
                    groups = ((8 << gen_width) - 7) / 7;
                end
                else begin
                    groups = (8 << gen_width) / 7;
                end
                for (int i = 0; i < groups; i++)
                    queue_byte(BYTE_ALL, 1'b0);
                queue_byte(8'($urandom_range(1, 127)), 1'($urandom_range(0, 1)));
            end
        endcase
    endtask

    // Stimulus sequence and end of run.
    initial begin
        vsd_width_t wc;
        logic       sgn;
        int         start;

        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = '0;
        cfg_data                 = '0;
        byte_if.valid            = 1'b0;
        byte_if.byte_value       = 8'h00;
        byte_if.last_in_buffer   = 1'b0;
        result_if.ready          = 1'b0;
        byte_taken               = 1'b0;
        calm                     = 1'b0;
        bytes_queued             = 0;
        bytes_accepted           = 0;
        mismatch_count           = 0;
        cycle_count              = 0;
        gen_width                = WC_64;
        gen_signed               = 1'b0;
        pred_width               = WC_64;
        pred_signed              = 1'b0;
        dec_busy                 = 1'b0;
        dec_acc                  = '0;
        dec_pos                  = '0;
        dec_count                = '0;
        dec_first                = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset settings (64-bit unsigned): zero, one
        // full group, a multi-byte value, the maximum pair, a zero
        // continuation, and a truncated varint.
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'hE5, 1'b0);
        queue_byte(8'h8E, 1'b0);
        queue_byte(8'h26, 1'b0);
        queue_byte(BYTE_CONT, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h81, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h85, 1'b1);
        wait_idle();

        // 8-bit unsigned: plain maximum, the value below it, a bit past the
        // width, and the maximum pair.
        configure(WC_8, 1'b0);
        queue_byte(BYTE_ALL, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'hFE, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(BYTE_CONT, 1'b0);
        queue_byte(8'h02, 1'b0);
        queue_byte(BYTE_CONT, 1'b0);
        queue_byte(8'h00, 1'b1);
        wait_idle();

        // 8-bit signed: the minimum code, the maximum pair, a negative
        // two-byte value, a negative single byte, and a zero continuation.
        configure(WC_8, 1'b1);
        queue_byte(BYTE_MIN_CODE, 1'b1);
        queue_byte(BYTE_CONT, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hC0, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'h00, 1'b0);
        wait_idle();

        // Random phases: every width in both modes, then random settings.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 8) begin
                case (p / 2)
                    0: wc = WC_64;
                    1: wc = WC_8;
                    2: wc = WC_16;
                    default: wc = WC_32;
                endcase
                sgn = 1'(p % 2);
            end
            else begin
                wc  = vsd_width_t'($urandom_range(0, 3));
                sgn = 1'($urandom_range(0, 1));
            end
            configure(wc, sgn);
            // One whole phase runs without any idle cycles on either side.
            calm  = (p == 4);
            start = bytes_queued;
            while (bytes_queued - start < PHASE_BYTES) begin
                int pick;
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    queue_random_varint();
                end
                else if (pick < 85) begin
                    queue_special();
                end
                else begin
                    // Noise bytes, now and then flagged as the buffer end.
                    repeat ($urandom_range(1, 4))
                        queue_byte(8'($urandom), $urandom_range(0, 99) < 15);
                end
                // Halfway through one phase the sender stops until the block
                // has delivered everything it owes.
                if (p == 6 && bytes_queued - start >= PHASE_BYTES / 2 &&
                    bytes_queued - start < PHASE_BYTES / 2 + 12)
                    wait_idle();
            end
            // A final byte flagged as the buffer end always yields a result,
            // so no varint is left open across a register write.
            queue_byte(8'($urandom), 1'b1);
            wait_idle();
            calm = 1'b0;
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
